[src/cda_pkg.sv]
// Shared types, constants and calendar helpers for the calendar date adder.
`timescale 1ns / 1ps

package cda_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    localparam logic signed [15:0] YEAR_MAX = 16'sd9999;
    localparam logic [3:0]  MONTH_MAX = 4'd12;

    // Divisors used by the shared divider
    localparam logic [8:0] DIV_12  = 9'd12;
    localparam logic [8:0] DIV_100 = 9'd100;
    localparam logic [8:0] DIV_400 = 9'd400;
    localparam int         DIVD_W  = 18;
    localparam logic [1:0] DIV_STEPS = 2'd2;

    // Reciprocals: x/3 = (x*43691)>>17 exact for x < 2^17,
    // x/100 = (x*5243)>>19 exact for x < 43690, x/400 is that shifted by two more
    localparam logic [15:0] RECIP_3   = 16'd43691;
    localparam logic [15:0] RECIP_100 = 16'd5243;
    localparam int          SH_3      = 17;
    localparam int          SH_100    = 19;
    localparam int          SH_400    = 21;

    localparam logic [8:0] R400_LAST = 9'd399;
    localparam logic [6:0] R100_LAST = 7'd99;

    // Microcode address
    typedef logic [4:0] upc_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV400,
        OP_DIV100,
        OP_SAVE400,
        OP_SAVE100,
        OP_CHECK,
        OP_FWD,
        OP_BWD,
        OP_MSTART,
        OP_MSET,
        OP_CLAMP,
        OP_FINISH
    } dp_op_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_DIV_BUSY,
        C_BAD,
        C_MONTH,
        C_NEG,
        C_FWD_MORE,
        C_BWD_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        upc_t   target;
    } ucode_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic div_busy;
        logic bad;
        logic month;
        logic neg;
        logic fwd_more;
        logic bwd_more;
    } dp_flags_t;

    // Finished result handed to the output register
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [1:0]  status;
    } result_t;

    // Leap test from the year's floor residues mod 400 and mod 100
    function automatic logic is_leap(input logic [8:0] r400, input logic [6:0] r100);
        return ((r400[1:0] == 2'd0) && (r100 != 7'd0)) || (r400 == 9'd0);
    endfunction

    function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[src/cda_div.sv]
// Divider by a small constant: reciprocal multiply, then a back-multiply for the remainder.
`timescale 1ns / 1ps

module cda_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cda_pkg::DIVD_W-1:0] dividend,
    input  logic [8:0]                 divisor,
    output logic                       busy,
    output logic [cda_pkg::DIVD_W-1:0] quotient,
    output logic [8:0]                 remainder
);

    logic [1:0]                 cnt_reg, cnt_next;
    logic [cda_pkg::DIVD_W-1:0] dvd_reg, dvd_next;
    logic [8:0]                 div_reg, div_next;
    logic [15:0]                q_reg, q_next;
    logic [8:0]                 rem_reg, rem_next;
    logic [15:0]                mul_a;
    logic [15:0]                mul_b;
    logic [31:0]                prod;
    logic [15:0]                q_est;
    logic [24:0]                back;

    // Quotient estimate: x/12 as (x/4)/3; x/100 and x/400 share the reciprocal of 100
    always_comb
    begin
        if (div_reg == cda_pkg::DIV_12)
        begin
            mul_a = dvd_reg[cda_pkg::DIVD_W-1:2];
            mul_b = cda_pkg::RECIP_3;
        end
        else
        begin
            mul_a = dvd_reg[15:0];
            mul_b = cda_pkg::RECIP_100;
        end
        prod = 32'(mul_a) * 32'(mul_b);
        case (div_reg)
            cda_pkg::DIV_12:  q_est = 16'(prod >> cda_pkg::SH_3);
            cda_pkg::DIV_100: q_est = 16'(prod >> cda_pkg::SH_100);
            default:          q_est = 16'(prod >> cda_pkg::SH_400);
        endcase
        back = 25'(q_reg) * 25'(div_reg);
    end

    // Step 1 registers the quotient, step 2 the remainder
    always_comb
    begin
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        div_next = div_reg;
        q_next   = q_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = cda_pkg::DIV_STEPS;
            dvd_next = dividend;
            div_next = divisor;
        end
        else if (cnt_reg == cda_pkg::DIV_STEPS)
        begin
            cnt_next = cnt_reg - 2'd1;
            q_next   = q_est;
        end
        else if (cnt_reg != 2'd0)
        begin
            cnt_next = cnt_reg - 2'd1;
            rem_next = 9'(dvd_reg - 18'(back));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign busy      = cnt_reg != 2'd0;
    assign quotient  = 18'(q_reg);
    assign remainder = rem_reg;

endmodule

[src/cda_dp.sv]
// Date datapath: working date, day counter, year residues and the shared divider.
`timescale 1ns / 1ps

module cda_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  cda_pkg::dp_op_t     op,
    input  logic                kind,
    input  logic [13:0]         year_in,
    input  logic [3:0]          month_in,
    input  logic [4:0]          day_in,
    input  logic signed [16:0]  amount,
    output cda_pkg::dp_flags_t  flags,
    output cda_pkg::result_t    result
);

    logic [13:0]        yi_reg, yi_next;
    logic [3:0]         mi_reg, mi_next;
    logic [4:0]         di_reg, di_next;
    logic               kind_reg, kind_next;
    logic signed [16:0] amt_reg, amt_next;
    logic               neg_reg, neg_next;
    logic [16:0]        n_reg, n_next;
    logic signed [15:0] y_reg, y_next;
    logic [3:0]         m_reg, m_next;
    logic [4:0]         d_reg, d_next;
    logic [8:0]         r400_reg, r400_next;
    logic [6:0]         r100_reg, r100_next;
    logic [1:0]         stat_reg, stat_next;
    logic               ovf_reg, ovf_next;

    logic               leap;
    logic [4:0]         len;
    logic [4:0]         prev_len;
    logic [17:0]        fwd_sum;
    logic               fwd_more;
    logic               bwd_more;
    logic               invalid;
    logic               out_of_range;
    logic signed [19:0] total;
    logic [8:0]         r400_inc, r400_dec;
    logic [6:0]         r100_inc, r100_dec;

    logic               div_start;
    logic [17:0]        div_dividend;
    logic [8:0]         div_divisor;
    logic               div_busy;
    logic [17:0]        div_quo;
    logic [8:0]         div_rem;

    cda_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Calendar terms of the working date
    always_comb
    begin
        leap     = cda_pkg::is_leap(r400_reg, r100_reg);
        len      = cda_pkg::days_in_month(m_reg, leap);
        prev_len = cda_pkg::days_in_month(m_reg - 4'd1, leap);
        fwd_sum  = 18'(d_reg) + 18'(n_reg);
        fwd_more = fwd_sum > 18'(len);
        bwd_more = n_reg >= 17'(d_reg);
        invalid  = (y_reg > cda_pkg::YEAR_MAX) || (m_reg == 4'd0)
                   || (m_reg > cda_pkg::MONTH_MAX) || (d_reg == 5'd0) || (d_reg > len);
        out_of_range = y_reg[15] || (y_reg > cda_pkg::YEAR_MAX);
        // months since year 0: y*12 + (m-1) + amount
        total = (20'(y_reg[13:0]) << 3) + (20'(y_reg[13:0]) << 2)
                + 20'(m_reg) - 20'sd1 + 20'(amt_reg);
        r400_inc = (r400_reg == cda_pkg::R400_LAST) ? 9'd0 : r400_reg + 9'd1;
        r400_dec = (r400_reg == 9'd0) ? cda_pkg::R400_LAST : r400_reg - 9'd1;
        r100_inc = (r100_reg == cda_pkg::R100_LAST) ? 7'd0 : r100_reg + 7'd1;
        r100_dec = (r100_reg == 7'd0) ? cda_pkg::R100_LAST : r100_reg - 7'd1;
    end

    // Divider hookup
    always_comb
    begin
        div_start    = (op == cda_pkg::OP_DIV400) || (op == cda_pkg::OP_DIV100)
                       || (op == cda_pkg::OP_MSTART);
        div_dividend = (op == cda_pkg::OP_MSTART) ? total[17:0] : 18'(y_reg[13:0]);
        case (op)
            cda_pkg::OP_DIV400: div_divisor = cda_pkg::DIV_400;
            cda_pkg::OP_DIV100: div_divisor = cda_pkg::DIV_100;
            default:            div_divisor = cda_pkg::DIV_12;
        endcase
    end

    // Operation decode
    always_comb
    begin
        yi_next   = yi_reg;
        mi_next   = mi_reg;
        di_next   = di_reg;
        kind_next = kind_reg;
        amt_next  = amt_reg;
        neg_next  = neg_reg;
        n_next    = n_reg;
        y_next    = y_reg;
        m_next    = m_reg;
        d_next    = d_reg;
        r400_next = r400_reg;
        r100_next = r100_reg;
        stat_next = stat_reg;
        ovf_next  = ovf_reg;
        case (op)
            cda_pkg::OP_LOAD:
            begin
                yi_next   = year_in;
                mi_next   = month_in;
                di_next   = day_in;
                kind_next = kind;
                amt_next  = amount;
                neg_next  = amount[16];
                n_next    = amount[16] ? 17'(-amount) : 17'(amount);
                y_next    = 16'(year_in);
                m_next    = month_in;
                d_next    = day_in;
                stat_next = cda_pkg::ST_OK;
                ovf_next  = 1'b0;
            end
            cda_pkg::OP_SAVE400: r400_next = div_rem;
            cda_pkg::OP_SAVE100: r100_next = 7'(div_rem);
            cda_pkg::OP_CHECK:   stat_next = invalid ? cda_pkg::ST_BAD : cda_pkg::ST_OK;
            // forward walk: one month per cycle
            cda_pkg::OP_FWD:
            begin
                if (fwd_more)
                begin
                    n_next = 17'(18'(n_reg) + 18'(d_reg) - 18'(len) - 18'd1);
                    d_next = 5'd1;
                    if (m_reg == cda_pkg::MONTH_MAX)
                    begin
                        m_next    = 4'd1;
                        y_next    = y_reg + 16'sd1;
                        r400_next = r400_inc;
                        r100_next = r100_inc;
                    end
                    else
                    begin
                        m_next = m_reg + 4'd1;
                    end
                end
                else
                begin
                    d_next = 5'(fwd_sum);
                end
            end
            // backward walk: one month per cycle
            cda_pkg::OP_BWD:
            begin
                if (bwd_more)
                begin
                    n_next = n_reg - 17'(d_reg);
                    if (m_reg == 4'd1)
                    begin
                        m_next    = cda_pkg::MONTH_MAX;
                        d_next    = 5'd31;
                        y_next    = y_reg - 16'sd1;
                        r400_next = r400_dec;
                        r100_next = r100_dec;
                    end
                    else
                    begin
                        m_next = m_reg - 4'd1;
                        d_next = prev_len;
                    end
                end
                else
                begin
                    d_next = d_reg - n_reg[4:0];
                end
            end
            cda_pkg::OP_MSTART: ovf_next = total[19];
            cda_pkg::OP_MSET:
            begin
                y_next = 16'(div_quo);
                m_next = 4'(div_rem) + 4'd1;
            end
            cda_pkg::OP_CLAMP:
            begin
                if (d_reg > len)
                begin
                    d_next = len;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        yi_reg   <= yi_next;
        mi_reg   <= mi_next;
        di_reg   <= di_next;
        kind_reg <= kind_next;
        amt_reg  <= amt_next;
        neg_reg  <= neg_next;
        n_reg    <= n_next;
        y_reg    <= y_next;
        m_reg    <= m_next;
        d_reg    <= d_next;
        r400_reg <= r400_next;
        r100_reg <= r100_next;
        stat_reg <= stat_next;
        ovf_reg  <= ovf_next;
    end

    // Status flags for the sequencer
    always_comb
    begin
        flags.div_busy = div_busy;
        flags.bad      = stat_reg == cda_pkg::ST_BAD;
        flags.month    = kind_reg;
        flags.neg      = neg_reg;
        flags.fwd_more = fwd_more;
        flags.bwd_more = bwd_more;
    end

    // Final result; errors echo the input date
    always_comb
    begin
        if (stat_reg == cda_pkg::ST_BAD)
        begin
            result = '{year: yi_reg, month: mi_reg, day: di_reg, status: cda_pkg::ST_BAD};
        end
        else if (ovf_reg || out_of_range)
        begin
            result = '{year: yi_reg, month: mi_reg, day: di_reg, status: cda_pkg::ST_OVF};
        end
        else
        begin
            result = '{year: y_reg[13:0], month: m_reg, day: d_reg, status: cda_pkg::ST_OK};
        end
    end

endmodule

[src/cda_seq.sv]
// Microcode sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps

module cda_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  cda_pkg::dp_flags_t flags,
    input  logic               in_valid,
    input  logic               out_busy,
    output cda_pkg::dp_op_t    op,
    output logic               idle
);

    // Program labels
    localparam cda_pkg::upc_t A_IDLE   = 5'd0;
    localparam cda_pkg::upc_t A_WAIT1  = 5'd2;
    localparam cda_pkg::upc_t A_WAIT2  = 5'd5;
    localparam cda_pkg::upc_t A_FWD    = 5'd11;
    localparam cda_pkg::upc_t A_BWD    = 5'd13;
    localparam cda_pkg::upc_t A_MON    = 5'd15;
    localparam cda_pkg::upc_t A_WAIT3  = 5'd16;
    localparam cda_pkg::upc_t A_WAIT4  = 5'd19;
    localparam cda_pkg::upc_t A_WAIT5  = 5'd22;
    localparam cda_pkg::upc_t A_FIN    = 5'd25;

    cda_pkg::upc_t   pc_reg, pc_next;
    cda_pkg::ucode_t uw;
    logic            take;

    // Control store
    function automatic cda_pkg::ucode_t ucode_rom(input cda_pkg::upc_t pc);
        cda_pkg::ucode_t w;
        case (pc)
            // fetch the transaction, then year residues of the start date
            5'd0:  w = '{cda_pkg::OP_LOAD,    cda_pkg::C_NO_INPUT, A_IDLE};
            5'd1:  w = '{cda_pkg::OP_DIV400,  cda_pkg::C_NEVER,    A_IDLE};
            5'd2:  w = '{cda_pkg::OP_NOP,     cda_pkg::C_DIV_BUSY, A_WAIT1};
            5'd3:  w = '{cda_pkg::OP_SAVE400, cda_pkg::C_NEVER,    A_IDLE};
            5'd4:  w = '{cda_pkg::OP_DIV100,  cda_pkg::C_NEVER,    A_IDLE};
            5'd5:  w = '{cda_pkg::OP_NOP,     cda_pkg::C_DIV_BUSY, A_WAIT2};
            5'd6:  w = '{cda_pkg::OP_SAVE100, cda_pkg::C_NEVER,    A_IDLE};
            // validate and dispatch
            5'd7:  w = '{cda_pkg::OP_CHECK,   cda_pkg::C_NEVER,    A_IDLE};
            5'd8:  w = '{cda_pkg::OP_NOP,     cda_pkg::C_BAD,      A_FIN};
            5'd9:  w = '{cda_pkg::OP_NOP,     cda_pkg::C_MONTH,    A_MON};
            5'd10: w = '{cda_pkg::OP_NOP,     cda_pkg::C_NEG,      A_BWD};
            // day shift forward
            5'd11: w = '{cda_pkg::OP_FWD,     cda_pkg::C_FWD_MORE, A_FWD};
            5'd12: w = '{cda_pkg::OP_NOP,     cda_pkg::C_ALWAYS,   A_FIN};
            // day shift backward
            5'd13: w = '{cda_pkg::OP_BWD,     cda_pkg::C_BWD_MORE, A_BWD};
            5'd14: w = '{cda_pkg::OP_NOP,     cda_pkg::C_ALWAYS,   A_FIN};
            // month shift: divide month count by 12, then new residues, then clamp the day
            5'd15: w = '{cda_pkg::OP_MSTART,  cda_pkg::C_NEVER,    A_IDLE};
            5'd16: w = '{cda_pkg::OP_NOP,     cda_pkg::C_DIV_BUSY, A_WAIT3};
            5'd17: w = '{cda_pkg::OP_MSET,    cda_pkg::C_NEVER,    A_IDLE};
            5'd18: w = '{cda_pkg::OP_DIV400,  cda_pkg::C_NEVER,    A_IDLE};
            5'd19: w = '{cda_pkg::OP_NOP,     cda_pkg::C_DIV_BUSY, A_WAIT4};
            5'd20: w = '{cda_pkg::OP_SAVE400, cda_pkg::C_NEVER,    A_IDLE};
            5'd21: w = '{cda_pkg::OP_DIV100,  cda_pkg::C_NEVER,    A_IDLE};
            5'd22: w = '{cda_pkg::OP_NOP,     cda_pkg::C_DIV_BUSY, A_WAIT5};
            5'd23: w = '{cda_pkg::OP_SAVE100, cda_pkg::C_NEVER,    A_IDLE};
            5'd24: w = '{cda_pkg::OP_CLAMP,   cda_pkg::C_NEVER,    A_IDLE};
            // hand off once the output register is free
            5'd25: w = '{cda_pkg::OP_FINISH,  cda_pkg::C_OUT_BUSY, A_FIN};
            5'd26: w = '{cda_pkg::OP_NOP,     cda_pkg::C_ALWAYS,   A_IDLE};
            default: w = '{cda_pkg::OP_NOP,   cda_pkg::C_ALWAYS,   A_IDLE};
        endcase
        return w;
    endfunction

    // Condition select and next step
    always_comb
    begin
        uw = ucode_rom(pc_reg);
        case (uw.cond)
            cda_pkg::C_NEVER:    take = 1'b0;
            cda_pkg::C_ALWAYS:   take = 1'b1;
            cda_pkg::C_NO_INPUT: take = !in_valid;
            cda_pkg::C_DIV_BUSY: take = flags.div_busy;
            cda_pkg::C_BAD:      take = flags.bad;
            cda_pkg::C_MONTH:    take = flags.month;
            cda_pkg::C_NEG:      take = flags.neg;
            cda_pkg::C_FWD_MORE: take = flags.fwd_more;
            cda_pkg::C_BWD_MORE: take = flags.bwd_more;
            cda_pkg::C_OUT_BUSY: take = out_busy;
            default:             take = 1'b0;
        endcase
        pc_next = take ? uw.target : pc_reg + 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= A_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign op   = uw.op;
    assign idle = pc_reg == A_IDLE;

endmodule

[src/calendar_date_adder.sv]
// Calendar date adder top level: handshakes, output register and checks.
`timescale 1ns / 1ps

// Adds a signed number of days (kind 0) or months (kind 1) to a Gregorian
// date and returns the new date with a status: 0 ok, 1 invalid input date,
// 2 result year outside 0..9999; on either error the input date comes back
// unchanged. One transaction is worked on at a time by a microcoded
// sequencer over a small datapath; in_stall is high from the cycle after
// acceptance until the sequencer is back at its first step. Taking the
// transaction in and checking the date includes two passes of the shared
// constant divider that finds the year's residues mod 400 and mod 100; an
// invalid date then goes straight to the finishing step. A day shift walks
// one month per cycle. A month shift makes three divider passes. The output
// register holds the result while the next transaction is already being
// taken in and worked on; while a result is still held by a stalled
// receiver the sequencer waits at its finishing step.
module calendar_date_adder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [13:0]        year_in,
    input  logic [3:0]         month_in,
    input  logic [4:0]         day_in,
    input  logic signed [16:0] amount,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [13:0]        year_out,
    output logic [3:0]         month_out,
    output logic [4:0]         day_out,
    output logic [1:0]         status
);

    cda_pkg::dp_op_t    op;
    cda_pkg::dp_flags_t flags;
    cda_pkg::result_t   result;
    logic               idle;
    logic               out_busy;
    logic               out_load;

    logic               out_valid_reg, out_valid_next;
    cda_pkg::result_t   out_reg;

    cda_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .flags    (flags),
        .in_valid (in_valid),
        .out_busy (out_busy),
        .op       (op),
        .idle     (idle)
    );

    cda_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .kind     (kind),
        .year_in  (year_in),
        .month_in (month_in),
        .day_in   (day_in),
        .amount   (amount),
        .flags    (flags),
        .result   (result)
    );

    // Output register: loads when empty or draining this cycle
    always_comb
    begin
        out_busy = out_valid_reg && out_stall;
        out_load = (op == cda_pkg::OP_FINISH) && !out_busy;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= result;
        end
    end

    assign in_stall  = !idle;
    assign out_valid = out_valid_reg;
    assign year_out  = out_reg.year;
    assign month_out = out_reg.month;
    assign day_out   = out_reg.day;
    assign status    = out_reg.status;

    // An accepted transaction takes the sequencer out of idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("sequencer still idle after accepting a transaction");

    // Status is always one of the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == cda_pkg::ST_OK || status == cda_pkg::ST_BAD
                       || status == cda_pkg::ST_OVF))
        else $error("undefined status code on output");

    // A good result is a date in range
    a_ok_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == cda_pkg::ST_OK) |->
        (year_out <= 14'd9999 && month_out >= 4'd1 && month_out <= 4'd12
         && day_out >= 5'd1))
        else $error("ok status with an out-of-range date");

    // A finished result never overwrites one the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !(out_valid_reg && out_stall))
        else $error("output register loaded while held");

endmodule
